// ===== design/assert_macros.svh =====
// assertion macros shared by the rtl files
// define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== design/nrtp_pkg.sv =====
// ----------------------------------------------------------------------------
// nrtp_pkg
// types and constants of the rmc time parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nrtp_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned VAL_W      = 7;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned POS_W      = 3;
    localparam int unsigned TIME_LEN   = 6;
    localparam int unsigned HEADER_LEN = 6;

    localparam logic [CNT_W-1:0] COMMA_CAP  = 5'd19;
    localparam logic [CNT_W-1:0] RMC_COMMAS = 5'd12;
    localparam logic [POS_W-1:0] POS_CAP    = 3'd7;
    localparam logic [POS_W-1:0] HDR_POS    = 3'd6;
    localparam logic [POS_W-1:0] TIME_POS   = 3'd6;

    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              end_of_sentence;
    } t_in_word;

    typedef struct packed {
        logic             time_found;
        logic [VAL_W-1:0] hour;
        logic [VAL_W-1:0] minute;
        logic [VAL_W-1:0] second;
    } t_out_word;

    typedef logic [TIME_LEN-1:0][CHAR_W-1:0] t_time_chars;

    // tracker result for the word being stepped
    typedef struct packed {
        logic        found;
        t_time_chars time_chars;
    } t_trk_status;

    // expected header text "$GPRMC", one character per position
    function automatic logic [CHAR_W-1:0] header_char(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4D;
            3'd5:    ch = 8'h43;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== design/nrtp_field_tracker.sv =====
// ----------------------------------------------------------------------------
// nrtp_field_tracker
// comma counting, header check and time field capture
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nrtp_field_tracker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire nrtp_pkg::t_in_word i_word,
    output nrtp_pkg::t_trk_status o_status
);

    logic [nrtp_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [nrtp_pkg::POS_W-1:0] r_pos, n_pos;
    logic                       r_header, n_header;
    nrtp_pkg::t_time_chars      r_time, n_time;
    logic                       header_final;

    always_comb begin
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_header = r_header;
        n_time   = r_time;
        if (i_word.char_in == nrtp_pkg::CH_COMMA) begin
            if (r_cnt == '0 && r_pos != nrtp_pkg::HDR_POS) begin
                n_header = 1'b0;
            end
            if (r_cnt < nrtp_pkg::COMMA_CAP) begin
                n_cnt = r_cnt + 1'b1;
            end
            n_pos = '0;
        end else begin
            if (r_cnt == '0) begin
                if (r_pos >= nrtp_pkg::HDR_POS ||
                    nrtp_pkg::header_char(r_pos) != i_word.char_in) begin
                    n_header = 1'b0;
                end
            end else if (r_cnt == 5'd1) begin
                for (int k = 0; k < nrtp_pkg::TIME_LEN; k++) begin
                    if (r_pos == nrtp_pkg::POS_W'(k)) begin
                        n_time[k] = i_word.char_in;
                    end
                end
            end
            if (r_pos < nrtp_pkg::POS_CAP) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    // a sentence with no comma closes field 0 at its last byte
    assign header_final = n_header && !(n_cnt == '0 && n_pos != nrtp_pkg::HDR_POS);

    always_comb begin
        o_status.found      = header_final && (n_cnt == nrtp_pkg::RMC_COMMAS);
        o_status.time_chars = r_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_pos    <= '0;
            r_header <= 1'b1;
            r_time   <= '0;
        end else if (i_step) begin
            if (i_word.end_of_sentence) begin
                r_cnt    <= '0;
                r_pos    <= '0;
                r_header <= 1'b1;
                r_time   <= '0;
            end else begin
                r_cnt    <= n_cnt;
                r_pos    <= n_pos;
                r_header <= n_header;
                r_time   <= n_time;
            end
        end
    end

    `ASSERT_CLK(a_clear_after_last, i_clk, i_rst_n, i_step && i_word.end_of_sentence |=> r_cnt == '0 && r_pos == '0 && r_header)
    `ASSERT_NEVER(a_cnt_over_cap, i_clk, i_rst_n, r_cnt > nrtp_pkg::COMMA_CAP)
    `ASSERT_CLK(a_time_empty_in_header, i_clk, i_rst_n, r_cnt == '0 |-> r_time == '0)

endmodule

`default_nettype wire

// ===== design/nrtp_time_decode.sv =====
// ----------------------------------------------------------------------------
// nrtp_time_decode
// turns the six captured characters into hour, minute and second
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nrtp_time_decode (
    input  nrtp_pkg::t_trk_status i_status,
    output nrtp_pkg::t_out_word   o_word
);

    function automatic logic is_digit(input logic [nrtp_pkg::CHAR_W-1:0] c);
        return (c >= nrtp_pkg::CH_ZERO) && (c <= nrtp_pkg::CH_NINE);
    endfunction

    // two digits give 10a+b, a lone leading digit gives a, else zero
    function automatic logic [nrtp_pkg::VAL_W-1:0] pair_value(
        input logic [nrtp_pkg::CHAR_W-1:0] a,
        input logic [nrtp_pkg::CHAR_W-1:0] b
    );
        logic [nrtp_pkg::VAL_W-1:0] va, vb, v;
        va = {3'b000, a[3:0]};
        vb = {3'b000, b[3:0]};
        if (!is_digit(a)) begin
            v = '0;
        end else if (!is_digit(b)) begin
            v = va;
        end else begin
            v = {va[3:0], 3'b000} + {va[5:0], 1'b0} + vb;
        end
        return v;
    endfunction

    always_comb begin
        o_word = '0;
        if (i_status.found) begin
            o_word.time_found = 1'b1;
            o_word.hour   = pair_value(i_status.time_chars[0], i_status.time_chars[1]);
            o_word.minute = pair_value(i_status.time_chars[2], i_status.time_chars[3]);
            o_word.second = pair_value(i_status.time_chars[4], i_status.time_chars[5]);
        end
    end

endmodule

`default_nettype wire

// ===== design/nmea_rmc_time_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_time_parser
// extracts the utc time from an rmc sentence, one byte per word
// ----------------------------------------------------------------------------
// usage
//   input channel: one sentence byte per word, with end_of_sentence set on the
//   final byte. output channel: one result word per sentence, issued for the
//   final byte only, carrying time_found and hour, minute, second.
//   result path: a byte taken into the input register is processed from there,
//   and processing a final byte writes the result word, so o_out_valid rises
//   once the final byte has been processed, which can wait for the receiver.
//   throughput: one byte per cycle while no final byte waits for the result
//   register, set by the input register feeding the single tracker update; an
//   output register lets the next sentence start while a result still waits.
//   receiver stall: ordinary bytes keep flowing; a final byte waits in the
//   input register until the output register is free, and input ready drops
//   only while it waits.
//   reset: synchronous, active low; clears both valid flags, the comma count,
//   the field position and the captured time, and sets the header flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nmea_rmc_time_parser (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // byte input
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire nrtp_pkg::t_in_word  i_in_word,
    // result output
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output nrtp_pkg::t_out_word      o_out_word
);

    // input register
    logic                  r_s1_valid;
    nrtp_pkg::t_in_word    r_s1_word;

    // result register
    logic                  r_out_valid, n_out_valid;
    nrtp_pkg::t_out_word   r_out_word;

    logic                  out_free;     // result register can take a word now
    logic                  s1_step;      // byte in the input register is processed
    logic                  out_load;     // a result word is written
    nrtp_pkg::t_trk_status trk_status;
    nrtp_pkg::t_out_word   dec_word;

    assign out_free   = !r_out_valid || i_out_ready;
    // only a final byte needs room in the result register
    assign s1_step    = r_s1_valid && (!r_s1_word.end_of_sentence || out_free);
    assign out_load   = s1_step && r_s1_word.end_of_sentence;
    assign o_in_ready = !r_s1_valid || s1_step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_word <= i_in_word;
        end
    end

    // sentence state and header check
    nrtp_field_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_step),
        .i_word   (r_s1_word),
        .o_status (trk_status)
    );

    // digit pairs to values
    nrtp_time_decode u_decode (
        .i_status (trk_status),
        .o_word   (dec_word)
    );

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= dec_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_CLK(a_load_needs_room, i_clk, i_rst_n, out_load |-> out_free)
    `ASSERT_CLK(a_found_in_range, i_clk, i_rst_n,
        r_out_valid && r_out_word.time_found |-> r_out_word.hour <= 7'd99 &&
        r_out_word.minute <= 7'd99 && r_out_word.second <= 7'd99)
    `ASSERT_CLK(a_not_found_zero, i_clk, i_rst_n,
        r_out_valid && !r_out_word.time_found |-> r_out_word.hour == '0 &&
        r_out_word.minute == '0 && r_out_word.second == '0)

endmodule

`default_nettype wire
